FILE: hdl/tpm_pkg.sv
package tpm_pkg;

    // Configuration register indexes
    localparam int CFG_AW = 2;
    localparam int CFG_DW = 11;

    typedef enum logic [CFG_AW-1:0] {
        CFG_LIMIT  = 2'd0,
        CFG_SCALE  = 2'd1,
        CFG_WIDTH  = 2'd2,
        CFG_HEIGHT = 2'd3
    } t_cfg_idx;

    localparam logic [23:0] COLOR_BLACK = 24'h000000;
    localparam logic [23:0] COLOR_WHITE = 24'hFFFFFF;
    localparam int          FRAC_BITS   = 4;

    // Widest table address the design supports
    localparam int TBL_AW_MAX = 12;

    localparam int DESC_Q_DEPTH = 4;
    localparam int OUT_Q_DEPTH  = 4;

    localparam logic FUNC_TABLE_WRITE = 1'b0;
    localparam logic FUNC_PIXEL       = 1'b1;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_LOOKUP = 2'd1,
        KIND_CONST  = 2'd2
    } t_kind;

    typedef struct packed {
        logic               func;
        logic [9:0]         table_addr;
        logic [23:0]        table_color;
        logic signed [15:0] thickness;
    } t_req;

    typedef struct packed {
        logic [23:0] pixel_color;
        logic        frame_last;
        logic        center_found;
        logic [9:0]  center_x;
        logic [9:0]  center_y;
    } t_rsp;

    // Work item passed from the classifier to the lookup side
    typedef struct packed {
        t_kind                 kind;
        logic [TBL_AW_MAX-1:0] addr;
        logic [23:0]           color;
        logic                  frame_last;
        logic                  center_found;
        logic [9:0]            center_x;
        logic [9:0]            center_y;
    } t_desc;

endpackage

FILE: hdl/tpm_ram.sv
module tpm_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: hdl/tpm_fifo.sv
module tpm_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    output logic                       o_full,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic                       o_empty,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);

    localparam int PW  = $clog2(DEPTH);
    localparam int CTW = $clog2(DEPTH+1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, n_wr_ptr;
    logic [PW-1:0]    r_rd_ptr, n_rd_ptr;
    logic [CTW-1:0]   r_count,  n_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CTW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_count = r_count;
    assign o_data  = r_mem[r_rd_ptr];

    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (do_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(DEPTH-1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (do_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(DEPTH-1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (do_push && !do_pop) begin
            n_count = r_count + CTW'(1);
        end else if (do_pop && !do_push) begin
            n_count = r_count - CTW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

endmodule

FILE: hdl/tpm_front.sv
module tpm_front
    import tpm_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_DIM     = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    input  logic              i_push,
    input  t_req              i_req,
    input  logic              i_q_full,
    output logic              o_q_push,
    output t_desc             o_q_data
);

    localparam int CW = $clog2(MAX_DIM);
    localparam int DW = $clog2(MAX_DIM+1);

    logic [10:0]        r_limit;
    logic               r_scale;
    logic [10:0]        r_width;
    logic [10:0]        r_height;
    logic [CW-1:0]      r_col, n_col;
    logic [CW-1:0]      r_row, n_row;
    logic signed [15:0] r_lowest, n_lowest;
    logic [CW-1:0]      r_best_col, n_best_col;
    logic [CW-1:0]      r_best_row, n_best_row;
    logic               r_found, n_found;

    logic               accept, pixel;
    logic               frame_start, is_min;
    logic signed [15:0] cur_lowest;
    logic [DW-1:0]      w_eff, h_eff;
    logic               col_last, row_last, last;
    logic [14:0]        mag;
    logic [18:0]        mag_wide, mag_x10;
    logic [14:0]        idx;
    logic               white;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_limit  <= 11'd1024;
            r_scale  <= 1'b0;
            r_width  <= 11'd1024;
            r_height <= 11'd1024;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                CFG_LIMIT:  r_limit  <= i_cfg_wdata;
                CFG_SCALE:  r_scale  <= i_cfg_wdata[0];
                CFG_WIDTH:  r_width  <= i_cfg_wdata;
                CFG_HEIGHT: r_height <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    assign accept = i_push && !i_q_full;
    assign pixel  = (i_req.func == FUNC_PIXEL);

    // zero acts as one, oversize acts as MAX_DIM
    always_comb begin
        if (r_width == '0) begin
            w_eff = DW'(1);
        end else if (32'(r_width) > MAX_DIM) begin
            w_eff = DW'(MAX_DIM);
        end else begin
            w_eff = DW'(r_width);
        end
        if (r_height == '0) begin
            h_eff = DW'(1);
        end else if (32'(r_height) > MAX_DIM) begin
            h_eff = DW'(MAX_DIM);
        end else begin
            h_eff = DW'(r_height);
        end
    end

    assign col_last = (DW'(r_col) + DW'(1)) >= w_eff;
    assign row_last = (DW'(r_row) + DW'(1)) >= h_eff;
    assign last     = col_last && row_last;

    // minimum search restarts at the first pixel of a frame
    assign frame_start = (r_col == '0) && (r_row == '0);
    assign cur_lowest  = frame_start ? $signed({1'b0, r_limit, 4'b0000}) : r_lowest;
    assign is_min      = (i_req.thickness > 16'sd0) && (i_req.thickness < cur_lowest);

    always_comb begin
        n_lowest   = cur_lowest;
        n_best_col = frame_start ? '0 : r_best_col;
        n_best_row = frame_start ? '0 : r_best_row;
        n_found    = frame_start ? 1'b0 : r_found;
        if (is_min) begin
            n_lowest   = i_req.thickness;
            n_best_col = r_col;
            n_best_row = r_row;
            n_found    = 1'b1;
        end
        if (col_last) begin
            n_col = '0;
            n_row = row_last ? '0 : r_row + CW'(1);
        end else begin
            n_col = r_col + CW'(1);
            n_row = r_row;
        end
    end

    // x10 as shift-and-add when scale is set, then drop fraction bits
    assign mag      = i_req.thickness[14:0];
    assign mag_wide = {4'b0000, mag};
    assign mag_x10  = (mag_wide << 3) + (mag_wide << 1);
    assign idx      = r_scale ? mag_x10[18:FRAC_BITS] : {4'b0000, mag[14:FRAC_BITS]};
    assign white    = (idx >= {4'b0000, r_limit}) || (32'(idx) >= TABLE_DEPTH);

    always_comb begin
        o_q_data              = '0;
        o_q_push              = 1'b0;
        if (!pixel) begin
            o_q_data.kind  = KIND_WRITE;
            o_q_data.addr  = TBL_AW_MAX'(i_req.table_addr);
            o_q_data.color = i_req.table_color;
            o_q_push       = i_push && (32'(i_req.table_addr) < TABLE_DEPTH);
        end else begin
            o_q_push = i_push;
            if (i_req.thickness[15]) begin
                o_q_data.kind  = KIND_CONST;
                o_q_data.color = COLOR_BLACK;
            end else if (white) begin
                o_q_data.kind  = KIND_CONST;
                o_q_data.color = COLOR_WHITE;
            end else begin
                o_q_data.kind = KIND_LOOKUP;
                o_q_data.addr = idx[TBL_AW_MAX-1:0];
            end
            o_q_data.frame_last   = last;
            o_q_data.center_found = last && n_found;
            o_q_data.center_x     = (last && n_found) ? 10'(n_best_col) : 10'd0;
            o_q_data.center_y     = (last && n_found) ? 10'(n_best_row) : 10'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col      <= '0;
            r_row      <= '0;
            r_lowest   <= $signed({1'b0, 11'd1024, 4'b0000});
            r_best_col <= '0;
            r_best_row <= '0;
            r_found    <= 1'b0;
        end else if (accept && pixel) begin
            r_col      <= n_col;
            r_row      <= n_row;
            r_lowest   <= n_lowest;
            r_best_col <= n_best_col;
            r_best_row <= n_best_row;
            r_found    <= n_found;
        end
    end

endmodule

FILE: hdl/tpm_back.sv
module tpm_back
    import tpm_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_q_empty,
    input  t_desc i_q_data,
    output logic  o_q_pop,
    output logic  o_empty,
    input  logic  i_pop,
    output t_rsp  o_rsp
);

    localparam int AW    = $clog2(TABLE_DEPTH);
    localparam int OCW   = $clog2(OUT_Q_DEPTH+1);
    localparam int RSP_W = $bits(t_rsp);

    logic             r_s1_valid, n_s1_valid;
    t_desc            r_s1_desc;
    logic [23:0]      ram_rdata;
    logic             ram_we, ram_re;
    logic [OCW-1:0]   out_count;
    logic             out_full;
    t_rsp             s1_rsp;
    logic [RSP_W-1:0] out_data;

    // pop only with room reserved for the request in flight
    assign o_q_pop = !i_q_empty &&
                     ((int'(out_count) + int'(r_s1_valid)) < OUT_Q_DEPTH);

    assign ram_we     = o_q_pop && (i_q_data.kind == KIND_WRITE);
    assign ram_re     = o_q_pop && (i_q_data.kind == KIND_LOOKUP);
    assign n_s1_valid = o_q_pop && (i_q_data.kind != KIND_WRITE);

    tpm_ram #(
        .WIDTH (24),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(i_q_data.addr)),
        .i_wdata (i_q_data.color),
        .i_re    (ram_re),
        .i_raddr (AW'(i_q_data.addr)),
        .o_rdata (ram_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= n_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_s1_desc <= i_q_data;
        end
    end

    always_comb begin
        s1_rsp.pixel_color  = (r_s1_desc.kind == KIND_LOOKUP) ? ram_rdata : r_s1_desc.color;
        s1_rsp.frame_last   = r_s1_desc.frame_last;
        s1_rsp.center_found = r_s1_desc.center_found;
        s1_rsp.center_x     = r_s1_desc.center_x;
        s1_rsp.center_y     = r_s1_desc.center_y;
    end

    tpm_fifo #(
        .WIDTH (RSP_W),
        .DEPTH (OUT_Q_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (r_s1_valid),
        .i_data  (s1_rsp),
        .o_full  (out_full),
        .i_pop   (i_pop),
        .o_data  (out_data),
        .o_empty (o_empty),
        .o_count (out_count)
    );

    assign o_rsp = out_data;

`ifndef NO_ASSERTIONS
    a_no_out_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> !out_full)
        else $error("result queue overflow");

    a_lookup_reaches_s1: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && (i_q_data.kind != KIND_WRITE)) |=> r_s1_valid)
        else $error("pixel request lost after pop");

    a_write_no_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_q_pop && (i_q_data.kind == KIND_WRITE)) |=> !r_s1_valid)
        else $error("table write produced a result");
`endif

endmodule

FILE: hdl/thickness_pseudocolor_map_top.sv
// Channel   Direction  Handshake             Payload
// request   in         push / full           i_req  (t_req)
// result    out        pop / empty           o_rsp  (t_rsp)
// config    in         i_cfg_we, i_cfg_addr  i_cfg_wdata
//
// One request per cycle sustained while results are popped; a pixel result passes
// the request queue, the table read register and the result queue before it shows on o_rsp.
// The table RAM has one write and one registered read port; writes and
// lookups go through it in request order. Table writes give no result.
// Reset is synchronous, active low; the table contents are not reset.
// With pop held low the result queue fills, then full rises on the input.
module thickness_pseudocolor_map_top
    import tpm_pkg::*;
#(
    parameter int TABLE_DEPTH = 1024,
    parameter int MAX_DIM     = 1024
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [CFG_AW-1:0] i_cfg_addr,
    input  logic [CFG_DW-1:0] i_cfg_wdata,
    input  logic              push,
    output logic              full,
    input  t_req              i_req,
    output logic              empty,
    input  logic              pop,
    output t_rsp              o_rsp
);

    localparam int DESC_W = $bits(t_desc);

    logic              q_push, q_full, q_pop, q_empty;
    t_desc             q_in;
    logic [DESC_W-1:0] q_out;
    logic [$clog2(DESC_Q_DEPTH+1)-1:0] q_count;

    assign full = q_full;

    tpm_front #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .MAX_DIM     (MAX_DIM)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .i_push      (push),
        .i_req       (i_req),
        .i_q_full    (q_full),
        .o_q_push    (q_push),
        .o_q_data    (q_in)
    );

    tpm_fifo #(
        .WIDTH (DESC_W),
        .DEPTH (DESC_Q_DEPTH)
    ) u_desc_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty),
        .o_count (q_count)
    );

    tpm_back #(
        .TABLE_DEPTH (TABLE_DEPTH)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_data  (t_desc'(q_out)),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_rsp     (o_rsp)
    );

`ifndef NO_ASSERTIONS
    a_count_matches_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_count == '0) == q_empty)
        else $error("request queue count and empty disagree");

    a_no_pop_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        q_empty |-> !q_pop)
        else $error("request queue popped while empty");

    a_full_blocks_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (q_full && !q_pop) |=> (q_count == $past(q_count)))
        else $error("request queue grew while full");
`endif

endmodule

FILE: sim/testbench.sv
module testbench;
    import tpm_pkg::*;

    localparam int TABLE_SIZE   = 1024;
    localparam int DIM_MAX      = 1024;
    localparam int SCALE_MULT   = 10;
    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;
    localparam int PHASE_ITEMS  = 30;

    // Color map predictor: table, geometry counters and minimum search
    class colormap_scoreboard;
        logic [23:0] color_mem [TABLE_SIZE];
        bit          written   [TABLE_SIZE];
        int unsigned limit_val, scale_on, width_val, height_val;
        int unsigned col_pos, row_pos, best_x, best_y;
        int          lowest;
        bit          found;
        t_rsp        expected_rsp [$];
        int          n_fail;

        function new();
            limit_val  = 1024;
            scale_on   = 0;
            width_val  = 1024;
            height_val = 1024;
            col_pos    = 0;
            row_pos    = 0;
            best_x     = 0;
            best_y     = 0;
            lowest     = 1024 << FRAC_BITS;
            found      = 1'b0;
            n_fail     = 0;
            foreach (written[i]) written[i] = 1'b0;
        endfunction

        function void write_register(t_cfg_idx idx, logic [CFG_DW-1:0] val);
            case (idx)
                CFG_LIMIT:  limit_val  = val;
                CFG_SCALE:  scale_on   = val[0];
                CFG_WIDTH:  width_val  = val;
                CFG_HEIGHT: height_val = val;
                default: ;
            endcase
        endfunction

        function int unsigned clamp_dim(int unsigned v);
            if (v == 0) return 1;
            if (v > DIM_MAX) return DIM_MAX;
            return v;
        endfunction

        // Table entry a sample reads, or -1 when it maps to black or white
        function int table_slot(int s);
            int unsigned idx;
            if (s < 0) return -1;
            idx = scale_on ? (s * SCALE_MULT) >> FRAC_BITS : s >> FRAC_BITS;
            if (idx >= limit_val || idx >= TABLE_SIZE) return -1;
            return idx;
        endfunction

        function int pending();
            return expected_rsp.size();
        endfunction

        function void note_request(t_req r);
            int          s;
            int          slot;
            int unsigned w, h;
            bit          last;
            t_rsp        e;
            if (r.func == FUNC_TABLE_WRITE) begin
                color_mem[r.table_addr] = r.table_color;
                written[r.table_addr]   = 1'b1;
                return;
            end
            w = clamp_dim(width_val);
            h = clamp_dim(height_val);
            s = $signed(r.thickness);
            if (col_pos == 0 && row_pos == 0) begin
                lowest = limit_val << FRAC_BITS;
                best_x = 0;
                best_y = 0;
                found  = 1'b0;
            end
            if (s > 0 && s < lowest) begin
                lowest = s;
                best_x = col_pos;
                best_y = row_pos;
                found  = 1'b1;
            end
            last = (col_pos + 1 >= w) && (row_pos + 1 >= h);
            slot = table_slot(s);
            if (s < 0)
                e.pixel_color = COLOR_BLACK;
            else if (slot < 0)
                e.pixel_color = COLOR_WHITE;
            else
                e.pixel_color = color_mem[slot];
            e.frame_last   = last;
            e.center_found = last && found;
            e.center_x     = (last && found) ? best_x[9:0] : 10'd0;
            e.center_y     = (last && found) ? best_y[9:0] : 10'd0;
            expected_rsp = {expected_rsp, e};
            // a counter past a shrunk bound wraps on this pixel
            if (col_pos + 1 >= w) begin
                col_pos = 0;
                row_pos = (row_pos + 1 >= h) ? 0 : row_pos + 1;
            end else begin
                col_pos++;
            end
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
                n_fail++;
            end
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (expected_rsp.size() == 0) begin
                $error("result 0x%0h with nothing expected", got);
                n_fail++;
                return;
            end
            want = expected_rsp.pop_front();
            compare_field("pixel_color", want.pixel_color, got.pixel_color);
            compare_field("frame_last", want.frame_last, got.frame_last);
            compare_field("center_found", want.center_found, got.center_found);
            compare_field("center_x", want.center_x, got.center_x);
            compare_field("center_y", want.center_y, got.center_y);
        endfunction
    endclass

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [CFG_AW-1:0] i_cfg_addr;
    logic [CFG_DW-1:0] i_cfg_wdata;
    logic              push;
    logic              full;
    t_req              i_req;
    logic              empty;
    logic              pop;
    t_rsp              o_rsp;

    colormap_scoreboard sb = new();

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;
    bit hold_start     = 1'b0;

    thickness_pseudocolor_map_top i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_wdata (i_cfg_wdata),
        .push        (push),
        .full        (full),
        .i_req       (i_req),
        .empty       (empty),
        .pop         (pop),
        .o_rsp       (o_rsp)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("Some tests failed");
        $finish;
    end

    // Result side: check on accept, then choose pop for the next edge
    initial begin
        pop <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && pop && !empty) sb.check_result(o_rsp);
            if (hold_start) begin
                hold_start = 1'b0;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                pop <= 1'b0;
                hold_left--;
            end else begin
                pop <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    function automatic t_req random_req();
        t_req r;
        r.func        = $urandom_range(1);
        r.table_addr  = $urandom;
        r.table_color = $urandom;
        r.thickness   = $urandom;
        return r;
    endfunction

    // Returns at the edge where the request was taken; push stays high
    task automatic push_request(t_req r);
        while ($urandom_range(99) < send_idle_pct) begin
            push  <= 1'b0;
            i_req <= random_req();
            @(posedge i_clk);
        end
        push  <= 1'b1;
        i_req <= r;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.note_request(r);
    endtask

    task automatic send_table_write(int addr, logic [23:0] color);
        t_req r;
        r             = random_req();
        r.func        = FUNC_TABLE_WRITE;
        r.table_addr  = addr[9:0];
        r.table_color = color;
        push_request(r);
    endtask

    // Loads the entry first if this sample would read an unwritten one
    task automatic send_pixel(int s);
        logic signed [15:0] sample;
        int                 slot;
        t_req               r;
        sample = s[15:0];
        slot   = sb.table_slot(sample);
        if (slot >= 0 && !sb.written[slot])
            send_table_write(slot, $urandom_range(24'hFFFFFF));
        r           = random_req();
        r.func      = FUNC_PIXEL;
        r.thickness = sample;
        push_request(r);
    endtask

    task automatic wait_drained();
        push <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        // table writes in flight give no result
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_register(t_cfg_idx idx, int unsigned val);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_wdata <= val[CFG_DW-1:0];
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        sb.write_register(idx, val[CFG_DW-1:0]);
    endtask

    function automatic int pick_thickness();
        int unsigned        pick, hi;
        logic signed [15:0] raw;
        pick = $urandom_range(99);
        hi   = sb.limit_val << FRAC_BITS;
        if (sb.scale_on) hi = hi / SCALE_MULT;
        if (hi > 32767) hi = 32767;
        raw = $urandom;
        if (pick < 12) return -int'($urandom_range(32768, 1));
        if (pick < 17) return 0;
        if (pick < 75 && hi > 1) return $urandom_range(hi - 1, 1);
        if (pick < 85) return int'(hi) + int'($urandom_range(32)) - 16;
        return raw;
    endfunction

    function automatic int unsigned pick_limit();
        case ($urandom_range(5))
            0:       return 0;
            1:       return 1024;
            2:       return 2047;
            default: return $urandom_range(1024, 1);
        endcase
    endfunction

    function automatic int unsigned pick_dim();
        if ($urandom_range(99) < 80) return $urandom_range(8, 1);
        case ($urandom_range(3))
            0:       return 0;
            1:       return 1024;
            2:       return 2047;
            default: return $urandom_range(2047);
        endcase
    endfunction

    initial begin
        i_rst_n     <= 1'b0;
        push        <= 1'b0;
        i_req       <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_addr  <= '0;
        i_cfg_wdata <= '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: table ends, sign and limit edges under reset settings
        send_table_write(0, COLOR_BLACK);
        send_table_write(TABLE_SIZE - 1, COLOR_WHITE);
        send_pixel(0);
        send_pixel(-32768);
        send_pixel(-1);
        send_pixel(1);
        send_pixel(32767);
        send_pixel(16383);
        send_pixel(16384);

        // limit above the table depth
        set_register(CFG_LIMIT, 2047);
        send_pixel(1100 << FRAC_BITS);
        send_pixel(32767);

        // scaled mode around the top entry
        set_register(CFG_SCALE, 1);
        set_register(CFG_LIMIT, 1024);
        send_pixel(1638);
        send_pixel(1639);
        send_pixel(16);

        // zero geometry acts as a 1x1 frame
        set_register(CFG_WIDTH, 0);
        set_register(CFG_HEIGHT, 0);
        send_pixel(5);
        send_pixel(0);
        send_pixel(-3);

        // zero limit: all white, no minimum
        set_register(CFG_LIMIT, 0);
        send_pixel(5);

        // oversized width, then shrink it mid-row
        set_register(CFG_SCALE, 0);
        set_register(CFG_LIMIT, 1024);
        set_register(CFG_WIDTH, 2047);
        set_register(CFG_HEIGHT, 1);
        repeat (6) send_pixel(pick_thickness());
        set_register(CFG_WIDTH, 4);
        send_pixel(pick_thickness());

        // long pop hold-off while requests keep coming
        set_register(CFG_WIDTH, 3);
        set_register(CFG_HEIGHT, 2);
        hold_start = 1'b1;
        repeat (30) send_pixel(pick_thickness());

        for (int ph = 0; ph < 8; ph++) begin
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 58; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 58; end
                default: begin send_idle_pct = 36; recv_stall_pct = 36; end
            endcase
            set_register(CFG_LIMIT, pick_limit());
            set_register(CFG_SCALE, $urandom_range(1));
            set_register(CFG_WIDTH, pick_dim());
            set_register(CFG_HEIGHT, pick_dim());
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(99) < 15)
                    send_table_write($urandom_range(TABLE_SIZE - 1), $urandom_range(24'hFFFFFF));
                else
                    send_pixel(pick_thickness());
            end
        end

        send_idle_pct  = 0;
        recv_stall_pct = 0;
        wait_drained();
        if (sb.n_fail == 0 && sb.pending() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
